// ===== rtl/core/gnea_pkg.sv =====
package gnea_pkg;

	// shared multiplier operand and product widths
	localparam int OPW   = 34;
	localparam int PRODW = 2 * OPW;

	// energy scale factors, unsigned Q0.32
	localparam logic [31:0] K_OSM  = 32'd2586859;
	localparam logic [31:0] K_SOLV = 32'd1293429;

	// register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_GRID_SIZE = 3'd0,
		REG_C1        = 3'd1,
		REG_C2        = 3'd2,
		REG_C3        = 3'd3,
		REG_C4        = 3'd4,
		REG_C5        = 3'd5,
		REG_INV_VOL   = 3'd6,
		REG_ION_EN    = 3'd7
	} reg_idx_t;

	typedef logic signed [OPW-1:0]   mul_op_t;
	typedef logic signed [PRODW-1:0] mul_prod_t;

endpackage

// ===== rtl/core/gnea_mul.sv =====
module gnea_mul import gnea_pkg::*; (
	input  logic      clk,
	input  mul_op_t   a,
	input  mul_op_t   b,
	output mul_prod_t prod_q
);

	// one registered signed multiply per cycle
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

// ===== rtl/core/grid_nonlinear_energy_accumulator_core.sv =====
// A solvent point runs the divisions, Horner steps and charge and energy terms, plus a
// charge word when ion_en is set, before the next accept; a non-solvent point only
// advances the raster. The final point adds the scaled totals; a held result word stalls.
// Throughput is set by the single shared 34x34 multiplier that carries the coefficient
// division, both Horner chains and all scalings.
// Reset (arst_n low, asynchronous) restores the register defaults and clears the
// positions, sums, entry count and the output word.
module grid_nonlinear_energy_accumulator_core import gnea_pkg::*; #(
	parameter int MAX_GRID = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [31:0]         wr_data,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic signed [31:0]  potential,
	input  logic                in_solvent,
	output logic                result_valid,
	input  logic                result_ready,
	output logic                kind,
	output logic [7:0]          grid_x,
	output logic [7:0]          grid_y,
	output logic [7:0]          grid_z,
	output logic signed [31:0]  charge,
	output logic signed [63:0]  solvation_energy,
	output logic signed [63:0]  osmotic_energy,
	output logic signed [63:0]  total_energy,
	output logic [24:0]         entry_count,
	output logic                last
);

	localparam logic [8:0] MaxG = 9'(MAX_GRID);

	typedef enum logic [4:0] {
		S_IDLE, S_DIV, S_DIV5, S_HU, S_HT, S_TP, S_V, S_CH, S_OS, S_SV, S_ENT, S_POS,
		S_TOT0, S_TOT1, S_TOT2, S_TOT3, S_TOT4, S_TOT5, S_TOT6, S_TOT7, S_TOT8, S_TOT9
	} state_t;

	state_t state_q;

	// configuration
	logic [8:0]         grid_size_q;
	logic signed [31:0] coef_q [1:5];
	logic [31:0]        inv_vol_q;
	logic               ion_en_q;

	// per-point working registers
	logic signed [31:0] phi_q, t_q, u_q, tp_q, v_q, charge_q;
	logic signed [31:0] d_q [1:5];
	logic [1:0]         f_q;
	logic               final_q, ex_q, ey_q;
	logic [2:0]         k_q;
	logic [7:0]         px_q, py_q, pz_q;
	logic signed [63:0] ssum_q, osum_q, se_q, oe_q;
	logic [63:0]        lo_q;
	logic [24:0]        cnt_q;

	mul_op_t   mul_a, mul_b;
	mul_prod_t prod_q;

	gnea_mul u_mul (
		.clk   (clk),
		.a     (mul_a),
		.b     (mul_b),
		.prod_q(prod_q)
	);

	// saturate to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		if (v > 49'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -49'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// rounded Q16.16 product from the multiplier
	function automatic logic signed [31:0] mulq(input mul_prod_t p);
		logic signed [63:0] s;
		s = p[63:0] + 64'sd32768;
		return sat32(49'(s >>> 16));
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return s[63:0];
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? (~v) + 64'd1 : v;
	endfunction

	// divisor n = k+1 for the derived coefficient of order k
	function automatic logic [32:0] div_recip(input logic [2:0] k);
		unique case (k)
			3'd1, 3'd3: return 33'h1_0000_0000;
			3'd2, 3'd5: return 33'd5726623062;
			3'd4:       return 33'd6871947674;
			default:    return 33'd0;
		endcase
	endfunction

	function automatic logic [32:0] div_mag(input logic signed [31:0] c, input logic [2:0] k);
		logic [32:0] m;
		m = c[31] ? 33'(-33'sd0 - 33'(c)) : 33'(c);
		return m + 33'((k + 3'd1) >> 1);
	endfunction

	function automatic logic signed [31:0] div_res(input mul_prod_t p,
		input logic signed [31:0] c, input logic [2:0] k);
		logic [31:0] q;
		unique case (k)
			3'd1:       q = p[64:33];
			3'd2, 3'd3: q = p[65:34];
			3'd4, 3'd5: q = p[66:35];
			default:    q = '0;
		endcase
		return (c <= 32'sd0) ? q : -q;
	endfunction

	// round half up on the face shift
	function automatic logic signed [31:0] rsh32(input logic signed [31:0] v,
		input logic [1:0] f);
		logic signed [33:0] s;
		s = 34'(v);
		unique case (f)
			2'd0: return v;
			2'd1: return 32'((s + 34'sd1) >>> 1);
			2'd2: return 32'((s + 34'sd2) >>> 2);
			2'd3: return 32'((s + 34'sd4) >>> 3);
			default: return v;
		endcase
	endfunction

	function automatic logic signed [63:0] rsh64(input logic signed [63:0] v,
		input logic [1:0] f);
		unique case (f)
			2'd0: return v;
			2'd1: return (v + 64'sd1) >>> 1;
			2'd2: return (v + 64'sd2) >>> 2;
			2'd3: return (v + 64'sd4) >>> 3;
			default: return v;
		endcase
	endfunction

	// merge two partial products, round magnitude half away, saturate
	function automatic logic signed [63:0] scale_fin(input logic [63:0] hi,
		input logic [63:0] lo, input logic neg, input logic sh32);
		logic [80:0] r;
		logic [63:0] lim;
		if (sh32) r = {17'd0, hi} + (({17'd0, lo} + (81'd1 << 31)) >> 32);
		else      r = ({17'd0, hi} << 16) + (({17'd0, lo} + (81'd1 << 15)) >> 16);
		lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		if (r > {17'd0, lim}) r = {17'd0, lim};
		return neg ? -r[63:0] : r[63:0];
	endfunction

	// position flags of the incoming point
	logic [8:0] eff_g, last_i;
	logic       ex, ey, ez, fx, fy, fz;
	logic [1:0] face_cnt;

	always_comb begin
		if (grid_size_q == 9'd0) eff_g = 9'd1;
		else if (grid_size_q > MaxG) eff_g = MaxG;
		else eff_g = grid_size_q;
		last_i   = eff_g - 9'd1;
		ex       = {1'b0, px_q} >= last_i;
		ey       = {1'b0, py_q} >= last_i;
		ez       = {1'b0, pz_q} >= last_i;
		fx       = (px_q == 8'd0) || ex;
		fy       = (py_q == 8'd0) || ey;
		fz       = (pz_q == 8'd0) || ez;
		face_cnt = 2'(fx) + 2'(fy) + 2'(fz);
	end

	logic [63:0] ssum_mag, osum_mag, oe_mag;
	logic [31:0] tp_mag;

	assign ssum_mag = mag64(ssum_q);
	assign osum_mag = mag64(osum_q);
	assign oe_mag   = mag64(oe_q);
	assign tp_mag   = tp_q[31] ? 32'(-tp_q) : tp_q;

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_DIV: begin
				mul_a = OPW'(div_mag(coef_q[k_q], k_q));
				mul_b = OPW'(div_recip(k_q));
			end
			S_DIV5: begin
				mul_a = OPW'(coef_q[5]);
				mul_b = OPW'(phi_q);
			end
			S_HU, S_TP: begin
				mul_a = OPW'(u_q);
				mul_b = OPW'(phi_q);
			end
			S_HT: begin
				mul_a = OPW'(t_q);
				mul_b = OPW'(phi_q);
			end
			S_V: begin
				mul_a = {2'b00, tp_mag};
				mul_b = {2'b00, inv_vol_q};
			end
			S_CH: begin
				mul_a = OPW'(v_q);
				mul_b = OPW'(phi_q);
			end
			S_OS: begin
				mul_a = OPW'(charge_q);
				mul_b = OPW'(phi_q);
			end
			S_TOT0: begin
				mul_a = {2'b00, ssum_mag[31:0]};
				mul_b = {2'b00, K_SOLV};
			end
			S_TOT1: begin
				mul_a = {2'b00, ssum_mag[63:32]};
				mul_b = {2'b00, K_SOLV};
			end
			S_TOT2: begin
				mul_a = {2'b00, osum_mag[31:0]};
				mul_b = {2'b00, K_OSM};
			end
			S_TOT3: begin
				mul_a = {2'b00, osum_mag[63:32]};
				mul_b = {2'b00, K_OSM};
			end
			S_TOT6: begin
				mul_a = {2'b00, oe_mag[31:0]};
				mul_b = {2'b00, inv_vol_q};
			end
			S_TOT7: begin
				mul_a = {2'b00, oe_mag[63:32]};
				mul_b = {2'b00, inv_vol_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	logic        can_load;
	logic        out_load;
	logic [47:0] ch_mag;
	logic signed [48:0] ch_val;

	assign can_load   = !result_valid || result_ready;
	assign out_load   = can_load && ((state_q == S_ENT) || (state_q == S_TOT9));
	assign item_ready = (state_q == S_IDLE);
	assign ch_mag     = 48'((prod_q[63:0] + 64'd32768) >> 16);
	assign ch_val     = tp_q[31] ? -49'(ch_mag) : 49'(ch_mag);

	// sequencer, configuration and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			grid_size_q      <= 9'd65;
			for (int i = 1; i <= 5; i++) coef_q[i] <= '0;
			inv_vol_q        <= 32'd65536;
			ion_en_q         <= 1'b0;
			px_q             <= '0;
			py_q             <= '0;
			pz_q             <= '0;
			ssum_q           <= '0;
			osum_q           <= '0;
			cnt_q            <= '0;
			k_q              <= '0;
			result_valid     <= 1'b0;
			kind             <= 1'b0;
			grid_x           <= '0;
			grid_y           <= '0;
			grid_z           <= '0;
			charge           <= '0;
			solvation_energy <= '0;
			osmotic_energy   <= '0;
			total_energy     <= '0;
			entry_count      <= '0;
			last             <= 1'b0;
		end else begin
			// register writes
			if (wr_en) begin
				unique case (reg_idx_t'(wr_index))
					REG_GRID_SIZE: grid_size_q <= wr_data[8:0];
					REG_C1:        coef_q[1]   <= wr_data;
					REG_C2:        coef_q[2]   <= wr_data;
					REG_C3:        coef_q[3]   <= wr_data;
					REG_C4:        coef_q[4]   <= wr_data;
					REG_C5:        coef_q[5]   <= wr_data;
					REG_INV_VOL:   inv_vol_q   <= wr_data;
					REG_ION_EN:    ion_en_q    <= wr_data[0];
					default:       ;
				endcase
			end

			// output word handshake
			if (out_load) result_valid <= 1'b1;
			else if (result_valid && result_ready) result_valid <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						phi_q   <= potential;
						f_q     <= face_cnt;
						final_q <= ex && ey && ez;
						ex_q    <= ex;
						ey_q    <= ey;
						k_q     <= 3'd1;
						state_q <= in_solvent ? S_DIV : S_POS;
					end
				end
				// derived coefficients, one division a cycle
				S_DIV: begin
					if (k_q != 3'd1) d_q[k_q - 3'd1] <= div_res(prod_q, coef_q[k_q - 3'd1],
						k_q - 3'd1);
					k_q <= k_q + 3'd1;
					if (k_q == 3'd5) state_q <= S_DIV5;
				end
				S_DIV5: begin
					d_q[5]  <= div_res(prod_q, coef_q[5], 3'd5);
					u_q     <= div_res(prod_q, coef_q[5], 3'd5);
					k_q     <= 3'd4;
					state_q <= S_HU;
				end
				// interleaved Horner steps
				S_HU: begin
					t_q     <= sat32(49'(mulq(prod_q)) + 49'(coef_q[k_q]));
					state_q <= S_HT;
				end
				S_HT: begin
					u_q <= sat32(49'(mulq(prod_q)) + 49'(d_q[k_q]));
					if (k_q == 3'd1) begin
						state_q <= S_TP;
					end else begin
						k_q     <= k_q - 3'd1;
						state_q <= S_HU;
					end
				end
				S_TP: begin
					tp_q    <= mulq(prod_q);
					state_q <= S_V;
				end
				S_V: begin
					v_q     <= mulq(prod_q);
					state_q <= S_CH;
				end
				S_CH: begin
					charge_q <= rsh32(sat32(ch_val), f_q);
					state_q  <= S_OS;
				end
				S_OS: begin
					osum_q  <= sat_add(osum_q, rsh64(prod_q[63:0], f_q));
					state_q <= S_SV;
				end
				S_SV: begin
					ssum_q <= sat_add(ssum_q, -prod_q[63:0]);
					if (ion_en_q) begin
						if (cnt_q != '1) cnt_q <= cnt_q + 25'd1;
						state_q <= S_ENT;
					end else begin
						state_q <= S_POS;
					end
				end
				// charge word
				S_ENT: begin
					if (can_load) begin
						kind             <= 1'b0;
						grid_x           <= px_q;
						grid_y           <= py_q;
						grid_z           <= pz_q;
						charge           <= charge_q;
						solvation_energy <= '0;
						osmotic_energy   <= '0;
						total_energy     <= '0;
						entry_count      <= '0;
						last             <= !final_q;
						state_q          <= S_POS;
					end
				end
				// raster advance
				S_POS: begin
					if (final_q) begin
						state_q <= S_TOT0;
					end else begin
						state_q <= S_IDLE;
						if (!ex_q) begin
							px_q <= px_q + 8'd1;
						end else begin
							px_q <= '0;
							if (!ey_q) begin
								py_q <= py_q + 8'd1;
							end else begin
								py_q <= '0;
								pz_q <= pz_q + 8'd1;
							end
						end
					end
				end
				// scaled totals
				S_TOT0: state_q <= S_TOT1;
				S_TOT1: begin
					lo_q    <= prod_q[63:0];
					state_q <= S_TOT2;
				end
				S_TOT2: begin
					se_q    <= scale_fin(prod_q[63:0], lo_q, ssum_q[63], 1'b1);
					state_q <= S_TOT3;
				end
				S_TOT3: begin
					lo_q    <= prod_q[63:0];
					state_q <= S_TOT4;
				end
				S_TOT4: begin
					oe_q    <= scale_fin(prod_q[63:0], lo_q, osum_q[63], 1'b1);
					state_q <= S_TOT5;
				end
				S_TOT5: begin
					oe_q    <= (oe_q == 64'sh8000_0000_0000_0000) ?
						64'sh7FFF_FFFF_FFFF_FFFF : -oe_q;
					state_q <= S_TOT6;
				end
				S_TOT6: state_q <= S_TOT7;
				S_TOT7: begin
					lo_q    <= prod_q[63:0];
					state_q <= S_TOT8;
				end
				S_TOT8: begin
					oe_q    <= scale_fin(prod_q[63:0], lo_q, oe_q[63], 1'b0);
					state_q <= S_TOT9;
				end
				S_TOT9: begin
					if (can_load) begin
						kind             <= 1'b1;
						grid_x           <= '0;
						grid_y           <= '0;
						grid_z           <= '0;
						charge           <= '0;
						solvation_energy <= se_q;
						osmotic_energy   <= oe_q;
						total_energy     <= sat_add(se_q, oe_q);
						entry_count      <= cnt_q;
						last             <= 1'b1;
						px_q             <= '0;
						py_q             <= '0;
						pz_q             <= '0;
						ssum_q           <= '0;
						osum_q           <= '0;
						cnt_q            <= '0;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
